FILE: src/ecl_pkg.sv
package ecl_pkg;

	typedef enum logic [1:0] {
		OP_INSERT    = 2'd0,
		OP_REMOVE    = 2'd1,
		OP_OVERWRITE = 2'd2,
		OP_READ      = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_ENTRY_DONE      = 3'd0,
		ST_REMOVE_DONE     = 3'd1,
		ST_OVERWRITE_DONE  = 3'd2,
		ST_INDEX_TOO_LARGE = 3'd3,
		ST_LIST_EMPTY      = 3'd4,
		ST_NO_SPACE        = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		ACT_HOLD   = 2'd0,
		ACT_INSERT = 2'd1,
		ACT_REMOVE = 2'd2,
		ACT_WRITE  = 2'd3
	} act_t;

	typedef struct packed {
		act_t       act;
		logic [7:0] ch;
	} cell_cmd_t;

	typedef enum logic {
		S_IDLE = 1'b0,
		S_READ = 1'b1
	} state_t;

	// offsets are 8 bits, so reads only reach the lowest 256 cells
	localparam int RD_SPAN       = 256;
	localparam int RD_GROUPS     = 16;
	localparam int RD_GROUP_SIZE = 16;

endpackage

FILE: src/ecl_in_if.sv
interface ecl_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] op;
	logic [7:0] ch;
	logic [7:0] offset;

	modport source (output valid, output op, output ch, output offset, input ready);
	modport sink (input valid, input op, input ch, input offset, output ready);
endinterface

FILE: src/ecl_out_if.sv
interface ecl_out_if;
	logic       valid;
	logic       ready;
	logic [2:0] status;
	logic [7:0] read_char;
	logic [8:0] line_length;

	modport source (output valid, output status, output read_char, output line_length,
		input ready);
	modport sink (input valid, input status, input read_char, input line_length,
		output ready);
endinterface

FILE: src/ecl_cell.sv
module ecl_cell #(
	parameter int TGT_W = 8,
	parameter int INDEX = 0
) (
	input  logic                  clk,
	input  ecl_pkg::cell_cmd_t    cmd,
	input  logic [TGT_W-1:0]      target,
	input  logic [7:0]            below,
	input  logic [7:0]            above,
	output logic [7:0]            data
);

	localparam logic [TGT_W-1:0] IDX = TGT_W'(INDEX);

	logic [7:0] data_q;
	logic [7:0] data_d;

	always_comb begin
		data_d = data_q;
		unique case (cmd.act)
			ecl_pkg::ACT_INSERT: begin
				// cells above the target move up one place
				if (IDX > target) data_d = below;
				else if (IDX == target) data_d = cmd.ch;
			end
			ecl_pkg::ACT_REMOVE: begin
				if (IDX >= target) data_d = above;
			end
			ecl_pkg::ACT_WRITE: begin
				if (IDX == target) data_d = cmd.ch;
			end
			ecl_pkg::ACT_HOLD: begin
				data_d = data_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		data_q <= data_d;
	end

	assign data = data_q;

endmodule

FILE: src/ecl_rdsel.sv
module ecl_rdsel #(
	parameter int NUM_CELLS = 256
) (
	input  logic       clk,
	input  logic [7:0] cells [NUM_CELLS],
	input  logic [7:0] idx,
	input  logic       load,
	output logic [7:0] data
);

	logic [7:0] entries [ecl_pkg::RD_SPAN];
	logic [7:0] grp_s1 [ecl_pkg::RD_GROUPS];
	logic [3:0] hi_s1;

	for (genvar j = 0; j < ecl_pkg::RD_SPAN; j++) begin : g_pad
		if (j < NUM_CELLS) begin : g_cell
			assign entries[j] = cells[j];
		end else begin : g_zero
			assign entries[j] = 8'h00;
		end
	end

	// first level picks within each group of sixteen
	always_ff @(posedge clk) begin
		if (load) begin
			for (int g = 0; g < ecl_pkg::RD_GROUPS; g++) begin
				grp_s1[g] <= entries[{4'(g), idx[3:0]}];
			end
			hi_s1 <= idx[7:4];
		end
	end

	assign data = grp_s1[hi_s1];

endmodule

FILE: src/editable_char_line_buffer_top.sv
// channel  dir  payload                                   accepted when
// req      in   op[1:0] ch[7:0] offset[7:0]               req.valid && req.ready
// rsp      out  status[2:0] read_char[7:0] line_length[8:0]  rsp.valid && rsp.ready
//
// insert, remove and overwrite finish in the cycle the request is taken;
// the result is loaded into the output register along with the cell update
// read goes through the registered two-level select over the low 256 cells
// reset empties the line; the character cells themselves are not cleared
// requests wait during a read or while the result register is full and not taken
module editable_char_line_buffer_top #(
	parameter int CAPACITY = 256
) (
	input  logic clk,
	input  logic arst_n,
	ecl_in_if.sink    req,
	ecl_out_if.source rsp
);

	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int TGT_W = $clog2(CAPACITY);
	localparam int CMP_W = (CNT_W > 8) ? CNT_W : 8;
	localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

	ecl_pkg::state_t  state_q, state_d;
	ecl_pkg::op_t     op;
	ecl_pkg::act_t    act;
	ecl_pkg::status_t st;
	ecl_pkg::cell_cmd_t cell_cmd;

	logic [CNT_W-1:0] n_q, n_nxt;
	logic [CMP_W-1:0] n_ext, k_ext, km1_ext;
	logic [TGT_W-1:0] tgt;
	logic             full, empty, do_ins, rd_ok, in_acc, out_free;
	logic             load_now, load_rd;

	logic             out_valid_q;
	logic [2:0]       status_q;
	logic [7:0]       char_q;
	logic [8:0]       len_q;
	logic [2:0]       rd_st_q;
	logic             rd_ok_q;

	logic [7:0]       cell_data [CAPACITY];
	logic [7:0]       rd_data;

	assign op      = ecl_pkg::op_t'(req.op);
	assign n_ext   = CMP_W'(n_q);
	assign k_ext   = CMP_W'(req.offset);
	assign km1_ext = k_ext - CMP_W'(1);
	assign full    = (n_q == CAP_CNT);
	assign empty   = (n_q == '0);
	assign out_free = !out_valid_q || rsp.ready;
	assign in_acc  = req.valid && req.ready;

	always_comb begin
		act    = ecl_pkg::ACT_HOLD;
		tgt    = '0;
		st     = ecl_pkg::ST_ENTRY_DONE;
		n_nxt  = n_q;
		rd_ok  = 1'b0;
		// overwrite at offset zero or on an empty line falls back to insert
		do_ins = (op == ecl_pkg::OP_INSERT) ||
			((op == ecl_pkg::OP_OVERWRITE) && (empty || (req.offset == 8'h00)));
		if (do_ins) begin
			if (full) begin
				st = ecl_pkg::ST_NO_SPACE;
			end else begin
				act   = ecl_pkg::ACT_INSERT;
				n_nxt = n_q + CNT_W'(1);
				if (k_ext >= n_ext) begin
					// goes to the front of the line
					tgt = n_ext[TGT_W-1:0];
					st  = (req.offset != 8'h00) ? ecl_pkg::ST_INDEX_TOO_LARGE
						: ecl_pkg::ST_ENTRY_DONE;
				end else begin
					tgt = k_ext[TGT_W-1:0];
				end
			end
		end else begin
			unique case (op)
				ecl_pkg::OP_REMOVE: begin
					if (empty) st = ecl_pkg::ST_LIST_EMPTY;
					else if (k_ext >= n_ext) st = ecl_pkg::ST_INDEX_TOO_LARGE;
					else begin
						act   = ecl_pkg::ACT_REMOVE;
						tgt   = k_ext[TGT_W-1:0];
						n_nxt = n_q - CNT_W'(1);
						st    = ecl_pkg::ST_REMOVE_DONE;
					end
				end
				ecl_pkg::OP_OVERWRITE: begin
					if (km1_ext >= n_ext) st = ecl_pkg::ST_INDEX_TOO_LARGE;
					else begin
						act = ecl_pkg::ACT_WRITE;
						tgt = km1_ext[TGT_W-1:0];
						st  = ecl_pkg::ST_OVERWRITE_DONE;
					end
				end
				ecl_pkg::OP_READ: begin
					if (empty) st = ecl_pkg::ST_LIST_EMPTY;
					else if (k_ext >= n_ext) st = ecl_pkg::ST_INDEX_TOO_LARGE;
					else begin
						st    = ecl_pkg::ST_ENTRY_DONE;
						rd_ok = 1'b1;
					end
				end
				ecl_pkg::OP_INSERT: begin
					st = ecl_pkg::ST_ENTRY_DONE;
				end
			endcase
		end
	end

	assign cell_cmd.act = in_acc ? act : ecl_pkg::ACT_HOLD;
	assign cell_cmd.ch  = req.ch;

	// cell j holds the character at offset j, so the last character sits in cell 0
	for (genvar j = 0; j < CAPACITY; j++) begin : g_cell
		logic [7:0] below, above;
		if (j == 0) begin : g_lo
			assign below = 8'h00;
		end else begin : g_lo_n
			assign below = cell_data[j-1];
		end
		if (j == CAPACITY - 1) begin : g_hi
			assign above = 8'h00;
		end else begin : g_hi_n
			assign above = cell_data[j+1];
		end
		ecl_cell #(
			.TGT_W (TGT_W),
			.INDEX (j)
		) u_cell (
			.clk    (clk),
			.cmd    (cell_cmd),
			.target (tgt),
			.below  (below),
			.above  (above),
			.data   (cell_data[j])
		);
	end

	ecl_rdsel #(
		.NUM_CELLS (CAPACITY)
	) u_rdsel (
		.clk   (clk),
		.cells (cell_data),
		.idx   (req.offset),
		.load  (in_acc && (op == ecl_pkg::OP_READ)),
		.data  (rd_data)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ecl_pkg::S_IDLE: if (in_acc && (op == ecl_pkg::OP_READ)) state_d = ecl_pkg::S_READ;
			ecl_pkg::S_READ: if (out_free) state_d = ecl_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		req.ready = 1'b0;
		load_now  = 1'b0;
		load_rd   = 1'b0;
		unique case (state_q)
			ecl_pkg::S_IDLE: begin
				req.ready = out_free;
				load_now  = in_acc && (op != ecl_pkg::OP_READ);
			end
			ecl_pkg::S_READ: begin
				load_rd = out_free;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ecl_pkg::S_IDLE;
			n_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_acc) n_q <= n_nxt;
			if (load_now || load_rd) out_valid_q <= 1'b1;
			else if (rsp.ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			rd_st_q <= st;
			rd_ok_q <= rd_ok;
		end
		if (load_now) begin
			status_q <= st;
			char_q   <= 8'h00;
			len_q    <= 9'(n_nxt);
		end else if (load_rd) begin
			status_q <= rd_st_q;
			char_q   <= rd_ok_q ? rd_data : 8'h00;
			len_q    <= 9'(n_q);
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.status      = status_q;
	assign rsp.read_char   = char_q;
	assign rsp.line_length = len_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		n_q <= CAP_CNT)
		else $error("line count above capacity");

	a_no_req_in_read: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ecl_pkg::S_READ) |-> !req.ready)
		else $error("request taken while a read is pending");

	a_edit_result: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && (op != ecl_pkg::OP_READ)) |=> rsp.valid)
		else $error("edit result not presented");

	a_count_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && (op == ecl_pkg::OP_READ)) |=> (n_q == $past(n_q)))
		else $error("read changed line length");

	a_char_only_on_read: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && (rsp.read_char != 8'h00)) |->
			(rsp.status == ecl_pkg::ST_ENTRY_DONE))
		else $error("read character on a failed result");

endmodule
